>>> hdl/dle_stuffed_imu_frame_deframer_unit_assert.svh
// Assertion macros shared by the deframer queue and back end
`ifndef DLE_STUFFED_IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define DLE_STUFFED_IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DLE_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DLE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dle_pkg.sv
// Shared types and constants of the DLE IMU frame deframer
package dle_pkg;

   // link control symbols
   localparam logic [7:0] SYM_DLE = 8'h10;
   localparam logic [7:0] SYM_SOH = 8'h01;
   localparam logic [7:0] SYM_EOT = 8'h04;

   // frame layout
   localparam int unsigned FRAME_BYTES_DEF = 22;
   localparam int unsigned WORD_BYTES      = 18;
   localparam int unsigned WORD_COUNT      = WORD_BYTES / 2;
   localparam int unsigned COUNT_W         = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam int unsigned IDX_W           = $clog2(WORD_BYTES);

   // command queue
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // classified beat passed from front to back
   typedef enum logic [1:0] {
      CMD_DATA  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_CLOSE = 2'd2
   } dle_cmd_type;

   typedef struct packed {
      dle_cmd_type cmd;
      logic [7:0]  data;
   } dle_beat_type;

endpackage

>>> hdl/dle_stuffed_imu_frame_deframer_unit.sv
// Top level of the DLE byte-stuffed IMU frame deframer
//
// Input channel req_: one raw serial byte per beat on req_rx_byte, taken when
// req_valid is high and req_stall is low. A byte is accepted every cycle while
// the internal beat queue has room; req_stall rises only when the queue is full.
// Result channel rsp_: one beat per closed frame (DLE EOT), carrying length_ok,
// nine signed 16-bit sensor words and the frame number; all zero on a bad length.
// Throughput is one byte per cycle while the beat queue has room, set by the
// framing state machine in the front end and the single-beat capture in the back end.
// The result becomes valid after the closing EOT byte is accepted: the close beat is
// first written into the queue and then loads the result register, later while the
// queue still holds older beats or the result register is held by a stall.
// When the receiver stalls, the result register holds its beat; the queue keeps
// taking bytes until it fills, then req_stall rises.
// Synchronous reset returns the front end to hunting for DLE SOH, empties the
// queue and clears the payload count and good-frame counter; no result is valid.
module dle_stuffed_imu_frame_deframer_unit
   import dle_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_length_ok,
   output logic signed [15:0]  rsp_accel_x,
   output logic signed [15:0]  rsp_accel_y,
   output logic signed [15:0]  rsp_accel_z,
   output logic signed [15:0]  rsp_gyro_x,
   output logic signed [15:0]  rsp_gyro_y,
   output logic signed [15:0]  rsp_gyro_z,
   output logic signed [15:0]  rsp_mag_x,
   output logic signed [15:0]  rsp_mag_y,
   output logic signed [15:0]  rsp_mag_z,
   output logic        [31:0]  rsp_frame_number
);

   logic         q_full;
   logic         q_empty;
   logic         push;
   logic         pop;
   dle_beat_type push_beat;
   dle_beat_type pop_beat;

   assign req_stall = q_full;

   // byte classification
   dle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_beat   (push_beat)
   );

   // decoupling queue
   dle_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .full      (q_full),
      .pop       (pop),
      .pop_beat  (pop_beat),
      .empty     (q_empty)
   );

   // capture and result
   dle_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_beat           (pop_beat),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_length_ok    (rsp_length_ok),
      .rsp_accel_x      (rsp_accel_x),
      .rsp_accel_y      (rsp_accel_y),
      .rsp_accel_z      (rsp_accel_z),
      .rsp_gyro_x       (rsp_gyro_x),
      .rsp_gyro_y       (rsp_gyro_y),
      .rsp_gyro_z       (rsp_gyro_z),
      .rsp_mag_x        (rsp_mag_x),
      .rsp_mag_y        (rsp_mag_y),
      .rsp_mag_z        (rsp_mag_z),
      .rsp_frame_number (rsp_frame_number)
   );

endmodule

>>> hdl/dle_front.sv
// Front end: DLE framing state machine that classifies raw bytes
module dle_front
   import dle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [7:0]   req_rx_byte,
   input  logic         q_full,
   output logic         push,
   output dle_beat_type push_beat
);

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_HUNT_ESC,
      ST_BODY,
      ST_BODY_ESC
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid & ~q_full;

   // classify the byte and pick the next framing state
   always_comb begin
      state_in       = state_ff;
      push           = 1'b0;
      push_beat.cmd  = CMD_DATA;
      push_beat.data = req_rx_byte;
      if (accept) begin
         case (state_ff)
            ST_HUNT: begin
               state_in = (req_rx_byte == SYM_DLE) ? ST_HUNT_ESC : ST_HUNT;
            end
            ST_HUNT_ESC: begin
               if (req_rx_byte == SYM_SOH) begin
                  push          = 1'b1;
                  push_beat.cmd = CMD_OPEN;
                  state_in      = ST_BODY;
               end else begin
                  state_in = ST_HUNT;
               end
            end
            ST_BODY: begin
               if (req_rx_byte == SYM_DLE) begin
                  state_in = ST_BODY_ESC;
               end else begin
                  push = 1'b1;
               end
            end
            ST_BODY_ESC: begin
               // escaped DLE is data, EOT closes, anything else is dropped
               if (req_rx_byte == SYM_EOT) begin
                  push          = 1'b1;
                  push_beat.cmd = CMD_CLOSE;
                  state_in      = ST_HUNT;
               end else begin
                  push     = (req_rx_byte == SYM_DLE);
                  state_in = ST_BODY;
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dle_cmd_fifo.sv
// Short queue of classified beats between front and back end
`include "dle_stuffed_imu_frame_deframer_unit_assert.svh"
module dle_cmd_fifo
   import dle_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  dle_beat_type push_beat,
   output logic         full,
   input  logic         pop,
   output dle_beat_type pop_beat,
   output logic         empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dle_beat_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_FULL);
   assign empty    = (cnt_ff == '0);
   assign pop_beat = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   `DLE_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
   `DLE_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")
   `DLE_ASSERT_NEXT(a_push_fills, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "fill count missed a push")

endmodule

>>> hdl/dle_back.sv
// Back end: payload capture, length check and result register
`include "dle_stuffed_imu_frame_deframer_unit_assert.svh"
module dle_back
   import dle_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  dle_beat_type        q_beat,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_length_ok,
   output logic signed [15:0]  rsp_accel_x,
   output logic signed [15:0]  rsp_accel_y,
   output logic signed [15:0]  rsp_accel_z,
   output logic signed [15:0]  rsp_gyro_x,
   output logic signed [15:0]  rsp_gyro_y,
   output logic signed [15:0]  rsp_gyro_z,
   output logic signed [15:0]  rsp_mag_x,
   output logic signed [15:0]  rsp_mag_y,
   output logic signed [15:0]  rsp_mag_z,
   output logic        [31:0]  rsp_frame_number
);

   localparam logic [COUNT_W-1:0] LEN_GOOD  = COUNT_W'(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] WORD_LIM  = COUNT_W'(WORD_BYTES);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         field_ff [WORD_BYTES];
   logic [31:0]        frame_cnt_ff, frame_cnt_in;
   logic               valid_ff, valid_in;
   logic               ok_ff;
   logic [15:0]        word_ff [WORD_COUNT];
   logic [31:0]        number_ff;
   logic               out_free;
   logic               load;
   logic               len_ok;
   logic               field_we;

   // a close beat waits until the result register can take it
   assign out_free = ~valid_ff | ~rsp_stall;
   assign q_pop    = ~q_empty & ((q_beat.cmd != CMD_CLOSE) | out_free);
   assign load     = q_pop & (q_beat.cmd == CMD_CLOSE);
   assign len_ok   = (count_ff == LEN_GOOD);
   assign field_we = q_pop & (q_beat.cmd == CMD_DATA) & (count_ff < WORD_LIM);

   // control state
   always_comb begin
      count_in     = count_ff;
      frame_cnt_in = frame_cnt_ff;
      valid_in     = valid_ff & rsp_stall;
      if (q_pop) begin
         case (q_beat.cmd)
            CMD_DATA: begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_OPEN: begin
               count_in = '0;
            end
            CMD_CLOSE: begin
               count_in = '0;
               valid_in = 1'b1;
               if (len_ok) begin
                  frame_cnt_in = frame_cnt_ff + 32'd1;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         frame_cnt_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         count_ff     <= count_in;
         frame_cnt_ff <= frame_cnt_in;
         valid_ff     <= valid_in;
      end
   end

   // payload byte capture
   always_ff @(posedge clock) begin
      if (field_we) begin
         field_ff[count_ff[IDX_W-1:0]] <= q_beat.data;
      end
   end

   // result register, zeroed on a bad length
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff     <= len_ok;
         number_ff <= len_ok ? frame_cnt_ff : 32'd0;
         for (int k = 0; k < WORD_COUNT; k++) begin
            word_ff[k] <= len_ok ? {field_ff[2*k], field_ff[2*k+1]} : 16'd0;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_length_ok    = ok_ff;
   assign rsp_accel_x      = signed'(word_ff[0]);
   assign rsp_accel_y      = signed'(word_ff[1]);
   assign rsp_accel_z      = signed'(word_ff[2]);
   assign rsp_gyro_x       = signed'(word_ff[3]);
   assign rsp_gyro_y       = signed'(word_ff[4]);
   assign rsp_gyro_z       = signed'(word_ff[5]);
   assign rsp_mag_x        = signed'(word_ff[6]);
   assign rsp_mag_y        = signed'(word_ff[7]);
   assign rsp_mag_z        = signed'(word_ff[8]);
   assign rsp_frame_number = number_ff;

   `DLE_ASSERT_NOW(a_bad_is_zero, valid_ff && !ok_ff, number_ff == 32'd0 && word_ff[0] == 16'd0,
      "bad-length result carries data")
   `DLE_ASSERT_NEXT(a_close_clears, load, count_ff == '0, "count not cleared at frame end")
   `DLE_ASSERT_NEXT(a_good_counts, load && len_ok, frame_cnt_ff == $past(frame_cnt_ff) + 32'd1,
      "good frame not counted")

endmodule

>>> tb/sv/tb_dle_stuffed_imu_frame_deframer_unit.sv
// Self-checking testbench for the DLE byte-stuffed IMU frame deframer
module tb_dle_stuffed_imu_frame_deframer_unit
   import dle_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // one decoded IMU frame as seen on the result channel
   typedef struct packed {
      logic             length_ok;
      logic [8:0][15:0] word;
      logic [31:0]      frame_number;
   } imu_frame_type;

   typedef enum logic [1:0] {
      LINK_HUNT,
      LINK_HUNT_ESC,
      LINK_BODY,
      LINK_BODY_ESC
   } link_state_type;

   // how the closing byte of a directed row is checked
   typedef enum logic [1:0] {
      ROW_PRED,
      ROW_ZERO,
      ROW_ONES
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   rx;
      logic [5:0]   reps;
      row_kind_type kind;
   } stim_row_type;

   localparam int STIM_ROWS      = 32;
   localparam int RANDOM_BYTES   = 1790;
   localparam int MAX_GAP        = 5;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_REPORTS    = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_length_ok;
   logic signed [15:0]  rsp_accel_x;
   logic signed [15:0]  rsp_accel_y;
   logic signed [15:0]  rsp_accel_z;
   logic signed [15:0]  rsp_gyro_x;
   logic signed [15:0]  rsp_gyro_y;
   logic signed [15:0]  rsp_gyro_z;
   logic signed [15:0]  rsp_mag_x;
   logic signed [15:0]  rsp_mag_y;
   logic signed [15:0]  rsp_mag_z;
   logic        [31:0]  rsp_frame_number;

   // deframer predictor state
   link_state_type      link_state = LINK_HUNT;
   logic [COUNT_W-1:0]  body_count = '0;
   logic [7:0]          word_bytes [WORD_BYTES];
   logic [31:0]         good_frames = '0;
   imu_frame_type       frame_q [$];

   int mismatches  = 0;
   int bytes_sent  = 0;
   int good_closed = 0;
   int bad_closed  = 0;
   int idle_count  = 0;
   bit tx_burst    = 1'b0;
   bit rx_burst    = 1'b0;

   string word_names [WORD_COUNT] = '{"accel_x", "accel_y", "accel_z",
                                      "gyro_x", "gyro_y", "gyro_z",
                                      "mag_x", "mag_y", "mag_z"};

   // directed stream: hunting noise, escapes, extremes, bad and overlong frames
   stim_row_type stim_rows [STIM_ROWS] = '{
      '{8'h00,   6'd2,  ROW_PRED},
      '{8'hFF,   6'd1,  ROW_PRED},
      // DLE DLE while hunting is a data pair, so neither SOH nor EOT acts
      '{SYM_DLE, 6'd2,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_EOT, 6'd1,  ROW_PRED},
      // good frame, all ones, first after reset
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{8'hFF,   6'd22, ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_EOT, 6'd1,  ROW_ONES},
      // signed extremes, a stuffed data DLE and a dropped DLE SOH inside the body
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{8'h80,   6'd1,  ROW_PRED},
      '{8'h00,   6'd1,  ROW_PRED},
      '{8'h7F,   6'd1,  ROW_PRED},
      '{8'hFF,   6'd1,  ROW_PRED},
      '{SYM_DLE, 6'd2,  ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{8'h00,   6'd17, ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_EOT, 6'd1,  ROW_PRED},
      // empty frame
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_EOT, 6'd1,  ROW_ZERO},
      // overlong frame, count saturates
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_SOH, 6'd1,  ROW_PRED},
      '{8'h5A,   6'd40, ROW_PRED},
      '{SYM_DLE, 6'd1,  ROW_PRED},
      '{SYM_EOT, 6'd1,  ROW_ZERO}
   };

   dle_stuffed_imu_frame_deframer_unit #(
      .FRAME_BYTES (FRAME_BYTES_DEF)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_length_ok    (rsp_length_ok),
      .rsp_accel_x      (rsp_accel_x),
      .rsp_accel_y      (rsp_accel_y),
      .rsp_accel_z      (rsp_accel_z),
      .rsp_gyro_x       (rsp_gyro_x),
      .rsp_gyro_y       (rsp_gyro_y),
      .rsp_gyro_z       (rsp_gyro_z),
      .rsp_mag_x        (rsp_mag_x),
      .rsp_mag_y        (rsp_mag_y),
      .rsp_mag_z        (rsp_mag_z),
      .rsp_frame_number (rsp_frame_number)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // payload byte capture, count saturates
   function automatic void store_payload(input logic [7:0] b);
      if (body_count < WORD_BYTES) word_bytes[body_count] = b;
      if (body_count != COUNT_MAX) body_count++;
   endfunction

   // advance the deframer by one byte, queue the frame it closes
   function automatic void predict_rx_byte(input logic [7:0] b, input row_kind_type kind);
      imu_frame_type frame;
      frame = '0;
      case (link_state)
         LINK_HUNT: begin
            link_state = (b == SYM_DLE) ? LINK_HUNT_ESC : LINK_HUNT;
         end
         LINK_HUNT_ESC: begin
            if (b == SYM_SOH) begin
               body_count = '0;
               link_state = LINK_BODY;
            end else begin
               link_state = LINK_HUNT;
            end
         end
         LINK_BODY: begin
            if (b == SYM_DLE) link_state = LINK_BODY_ESC;
            else store_payload(b);
         end
         default: begin
            if (b == SYM_EOT) begin
               if (body_count == FRAME_BYTES_DEF) begin
                  frame.length_ok = 1'b1;
                  for (int k = 0; k < WORD_COUNT; k++)
                     frame.word[k] = {word_bytes[2*k], word_bytes[2*k+1]};
                  frame.frame_number = good_frames;
                  good_frames++;
                  good_closed++;
               end else begin
                  bad_closed++;
               end
               body_count = '0;
               link_state = LINK_HUNT;
               // directed rows with a typed-in result replace the prediction
               if (kind == ROW_ZERO) begin
                  frame = '0;
               end else if (kind == ROW_ONES) begin
                  frame = '0;
                  frame.length_ok = 1'b1;
                  frame.word = '1;
               end
               frame_q.push_back(frame);
            end else begin
               // DLE DLE keeps a data DLE, any other escaped byte is dropped
               if (b == SYM_DLE) store_payload(b);
               link_state = LINK_BODY;
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endfunction

   // drive one input beat after a random gap, entered and left at a falling edge
   task automatic send_rx_byte(input logic [7:0] b, input row_kind_type kind);
      int gap;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_rx_byte(b, kind);
      bytes_sent++;
      @(negedge clock);
   endtask

   // mostly well-formed frames with random content, plus noise and broken frames
   task automatic send_random_frame();
      int         noise;
      int         len;
      logic [7:0] b;
      noise = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 1);
      repeat (noise) send_rx_byte(8'($urandom_range(0, 255)), ROW_PRED);
      // stray DLE ahead of the opener turns it into a data pair
      if ($urandom_range(0, 9) == 0) send_rx_byte(SYM_DLE, ROW_PRED);
      send_rx_byte(SYM_DLE, ROW_PRED);
      send_rx_byte(SYM_SOH, ROW_PRED);
      len = ($urandom_range(0, 9) < 7) ? FRAME_BYTES_DEF : $urandom_range(0, 34);
      for (int i = 0; i < len; i++) begin
         // dropped escape pair, SOH among them
         if ($urandom_range(0, 19) == 0) begin
            b = $urandom_range(0, 1) ? SYM_SOH : 8'($urandom_range(0, 255));
            if (b == SYM_DLE || b == SYM_EOT) b = 8'hA5;
            send_rx_byte(SYM_DLE, ROW_PRED);
            send_rx_byte(b, ROW_PRED);
         end
         b = ($urandom_range(0, 7) == 0) ? SYM_DLE : 8'($urandom_range(0, 255));
         if (b == SYM_DLE) send_rx_byte(SYM_DLE, ROW_PRED);
         send_rx_byte(b, ROW_PRED);
      end
      // most frames close, some run into the next one
      if ($urandom_range(0, 9) != 0) begin
         send_rx_byte(SYM_DLE, ROW_PRED);
         send_rx_byte(SYM_EOT, ROW_PRED);
      end
   endtask

   // result side: random stall per beat, compare against the oldest prediction
   initial begin
      int            gap;
      imu_frame_type seen;
      imu_frame_type want;
      do @(negedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         seen.length_ok    = rsp_length_ok;
         seen.word[0]      = rsp_accel_x;
         seen.word[1]      = rsp_accel_y;
         seen.word[2]      = rsp_accel_z;
         seen.word[3]      = rsp_gyro_x;
         seen.word[4]      = rsp_gyro_y;
         seen.word[5]      = rsp_gyro_z;
         seen.word[6]      = rsp_mag_x;
         seen.word[7]      = rsp_mag_y;
         seen.word[8]      = rsp_mag_z;
         seen.frame_number = rsp_frame_number;
         if (frame_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t ns: result beat with no frame pending, frame_number %0h",
                        $time, seen.frame_number);
         end else begin
            want = frame_q.pop_front();
            if (seen.length_ok !== want.length_ok)
               note_mismatch("length_ok", 32'(want.length_ok), 32'(seen.length_ok));
            for (int k = 0; k < WORD_COUNT; k++)
               if (seen.word[k] !== want.word[k])
                  note_mismatch(word_names[k], 32'(want.word[k]), 32'(seen.word[k]));
            if (seen.frame_number !== want.frame_number)
               note_mismatch("frame_number", want.frame_number, seen.frame_number);
         end
         @(negedge clock);
      end
   end

   // watchdog: cycles in a row with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else if (idle_count == WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // main sequence
   initial begin
      int directed_bytes;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      rsp_stall   = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r])
         repeat (stim_rows[r].reps) send_rx_byte(stim_rows[r].rx, stim_rows[r].kind);
      directed_bytes = bytes_sent;

      while (bytes_sent - directed_bytes < RANDOM_BYTES) send_random_frame();
      req_valid <= 1'b0;

      // let every predicted frame arrive, then watch for strays
      while (frame_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Fed %0d bytes (%0d directed); %0d frames closed, %0d good, %0d bad length",
               bytes_sent, directed_bytes, good_closed + bad_closed, good_closed, bad_closed);
      $display("Mismatching fields or stray beats: %0d", mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dle_pkg.sv
hdl/dle_front.sv
hdl/dle_cmd_fifo.sv
hdl/dle_back.sv
hdl/dle_stuffed_imu_frame_deframer_unit.sv
tb/sv/tb_dle_stuffed_imu_frame_deframer_unit.sv
